// File: hw/rtl/room_allocation_scheduler_top_assert.svh
// Assertion macros for the checker of the room allocation scheduler
`ifndef ROOM_ALLOCATION_SCHEDULER_TOP_ASSERT_SVH
`define ROOM_ALLOCATION_SCHEDULER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RAS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ras_pkg.sv
// Shared types and constants of the room allocation scheduler
`default_nettype none

package ras_pkg;

  localparam int ROOMS_DEF      = 16;
  localparam int TIME_BITS_DEF  = 40;
  localparam int COUNT_BITS_DEF = 24;

  localparam int CFG_W  = 5;
  localparam int ROOM_W = 4;

  localparam logic [CFG_W-1:0] ROOMS_IN_USE_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } ras_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ras_room_mem.sv
// Per-room store of busy-until time and use count, with per-entry valid bits
`default_nettype none

module ras_room_mem #(
  parameter int ROOMS      = 16,
  parameter int TIME_BITS  = 40,
  parameter int COUNT_BITS = 24,
  parameter int IDX_W      = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  clr,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output logic      [TIME_BITS-1:0]  rd_busy,
  output logic      [COUNT_BITS-1:0] rd_count,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_addr,
  input  wire logic [TIME_BITS-1:0]  wr_busy,
  input  wire logic [COUNT_BITS-1:0] wr_count
);

  localparam int WORD_W = TIME_BITS + COUNT_BITS;

  logic [WORD_W-1:0] mem [ROOMS];
  logic [ROOMS-1:0]  vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_busy, wr_count};
    end
    rd_data_r <= mem[rd_addr];
  end

  // An entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_busy  = rd_vld_r ? rd_data_r[WORD_W-1:COUNT_BITS] : '0;
  assign rd_count = rd_vld_r ? rd_data_r[COUNT_BITS-1:0]      : '0;

endmodule

`default_nettype wire

// File: hw/rtl/room_allocation_scheduler_top.sv
// Room allocation scheduler: top level with scan sequencer and result register
//
// Each booking request is accepted, then the room store is read once per room in
// use (the clamped room count), the last read is left to return, and then the
// chosen room is written back and the result register is loaded. The room store
// has a single read and a
// single write port, so rooms are visited one per cycle, and a new request is
// taken only once the previous one has written back. A pending result in the
// output register does not stall acceptance; it stalls only the next write-back.
// first_of_set clears all rooms at once, with no clearing pass.
// cfg_ready is always high; write it only while no request is in flight.
`default_nettype none

module room_allocation_scheduler_top
  import ras_pkg::*;
#(
  parameter int ROOMS      = ROOMS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_W-1:0]     cfg_rooms_in_use,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TIME_BITS-1:0] in_req_start,
  input  wire logic [TIME_BITS-1:0] in_end_time,
  input  wire logic                 in_first_of_set,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [ROOM_W-1:0]    out_room,
  output logic      [TIME_BITS-1:0] out_held_from,
  output logic      [TIME_BITS-1:0] out_held_until,
  output logic                      out_was_delayed,
  output logic      [ROOM_W-1:0]    out_busiest_room
);

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;

  ras_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_r;
  logic [IDX_W-1:0]      last_c, last_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  cmp_vld_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [TIME_BITS-1:0]  start_r, plain_until_r, len_r;
  logic [TIME_BITS-1:0]  len_c;

  logic                  found_r;
  logic [IDX_W-1:0]      free_idx_r, min_idx_r;
  logic [COUNT_BITS-1:0] free_cnt_r, min_cnt_r;
  logic [TIME_BITS-1:0]  min_busy_r;

  logic [COUNT_BITS-1:0] top_count_r;
  logic [IDX_W-1:0]      top_room_r;

  logic                  out_valid_r, out_was_delayed_r;
  logic [ROOM_W-1:0]     out_room_r, out_busiest_r;
  logic [TIME_BITS-1:0]  out_from_r, out_until_r;

  logic                  accept, issue, commit;
  logic [TIME_BITS-1:0]  rd_busy;
  logic [COUNT_BITS-1:0] rd_count;

  logic [IDX_W-1:0]      pick_c;
  logic [COUNT_BITS-1:0] cnt_c, cnt_new_c;
  logic [TIME_BITS-1:0]  from_c, until_c;
  logic [TIME_BITS:0]    sum_c;
  logic                  better_c;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ROOMS_IN_USE_RST;
    end else if (cfg_valid) begin
      cfg_r <= cfg_rooms_in_use;
    end
  end

  // Clamp the room count to 1..ROOMS and keep the last index to visit
  always_comb begin
    if (cfg_r == '0) begin
      last_c = '0;
    end else if (int'(cfg_r) > ROOMS) begin
      last_c = IDX_W'(ROOMS - 1);
    end else begin
      last_c = IDX_W'(cfg_r - 1'b1);
    end
  end

  assign len_c = (in_end_time > in_req_start) ? (in_end_time - in_req_start) : '0;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (rd_idx_r == last_r) state_nxt = ST_LAST;
      ST_LAST:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   issue    = 1'b1;
      ST_LAST:   ;
      ST_UPDATE: commit   = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Request latch and scan address
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r       <= in_req_start;
      plain_until_r <= (in_end_time > in_req_start) ? in_end_time : in_req_start;
      len_r         <= len_c;
      last_r        <= last_c;
    end
    cmp_idx_r <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (accept) begin
        rd_idx_r <= '0;
      end else if (issue && rd_idx_r != last_r) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  ras_room_mem #(
    .ROOMS      (ROOMS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (accept && in_first_of_set),
    .rd_addr  (rd_idx_r),
    .rd_busy  (rd_busy),
    .rd_count (rd_count),
    .wr_en    (commit),
    .wr_addr  (pick_c),
    .wr_busy  (until_c),
    .wr_count (cnt_new_c)
  );

  // Track the lowest free room and the earliest-freeing room as reads return
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (accept) begin
      found_r <= 1'b0;
    end else if (cmp_vld_r && !found_r && rd_busy <= start_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r && !found_r && rd_busy <= start_r) begin
      free_idx_r <= cmp_idx_r;
      free_cnt_r <= rd_count;
    end
    if (cmp_vld_r && (cmp_idx_r == '0 || rd_busy < min_busy_r)) begin
      min_idx_r  <= cmp_idx_r;
      min_busy_r <= rd_busy;
      min_cnt_r  <= rd_count;
    end
  end

  // Write-back values
  assign sum_c = {1'b0, min_busy_r} + {1'b0, len_r};

  always_comb begin
    if (found_r) begin
      pick_c  = free_idx_r;
      cnt_c   = free_cnt_r;
      from_c  = start_r;
      until_c = plain_until_r;
    end else begin
      pick_c  = min_idx_r;
      cnt_c   = min_cnt_r;
      from_c  = min_busy_r;
      until_c = sum_c[TIME_BITS] ? '1 : sum_c[TIME_BITS-1:0];
    end
  end

  // Saturate the use count
  assign cnt_new_c = (cnt_c == '1) ? cnt_c : cnt_c + 1'b1;
  assign better_c  = (cnt_new_c > top_count_r) ||
                     (cnt_new_c == top_count_r && pick_c < top_room_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= '0;
      top_room_r  <= '0;
    end else if (accept && in_first_of_set) begin
      top_count_r <= '0;
      top_room_r  <= '0;
    end else if (commit && better_c) begin
      top_count_r <= cnt_new_c;
      top_room_r  <= pick_c;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_room_r        <= ROOM_W'(pick_c);
      out_from_r        <= from_c;
      out_until_r       <= until_c;
      out_was_delayed_r <= !found_r;
      out_busiest_r     <= better_c ? ROOM_W'(pick_c) : ROOM_W'(top_room_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_room         = out_room_r;
  assign out_held_from    = out_from_r;
  assign out_held_until   = out_until_r;
  assign out_was_delayed  = out_was_delayed_r;
  assign out_busiest_room = out_busiest_r;

endmodule

`default_nettype wire

// File: hw/rtl/ras_checker.sv
// Port-level checker for the room allocation scheduler, bound to the top level
`default_nettype none

`include "room_allocation_scheduler_top_assert.svh"

module ras_checker
  import ras_pkg::*;
#(
  parameter int ROOMS     = ROOMS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [ROOM_W-1:0]    out_room,
  input wire logic [TIME_BITS-1:0] out_held_from,
  input wire logic [TIME_BITS-1:0] out_held_until,
  input wire logic [ROOM_W-1:0]    out_busiest_room
);

  `RAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_room) && $stable(out_held_until), "result dropped or changed while stalled")

  `RAS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken during a scan")

  `RAS_ASSERT_SAME(a_time_order, out_valid, out_held_until >= out_held_from, "booking ends before it starts")

  `RAS_ASSERT_SAME(a_room_range, out_valid, int'(out_room) < ROOMS && int'(out_busiest_room) < ROOMS, "room index beyond room count")

endmodule

bind room_allocation_scheduler_top ras_checker #(
  .ROOMS     (ROOMS),
  .TIME_BITS (TIME_BITS)
) u_ras_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_room         (out_room),
  .out_held_from    (out_held_from),
  .out_held_until   (out_held_until),
  .out_busiest_room (out_busiest_room)
);

`default_nettype wire
